FILE: design/frct_pkg.sv
// Shared types and codes for the fragment reassembly context table.
`default_nettype none

package frct_pkg;

    // Field widths of the request and response items
    localparam int FUNC_W     = 2;
    localparam int TERM_W     = 16;
    localparam int FRAG_W     = 8;
    localparam int LEN_W      = 16;
    localparam int STATUS_W   = 4;
    localparam int SLOT_OUT_W = 3;
    localparam int EXP_W      = 8;

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 40;

    // Function codes
    localparam logic [FUNC_W-1:0] FN_FRAG    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_RELEASE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LOOKUP  = 2'd2;

    // Fragment byte fields
    localparam logic [FRAG_W-1:0] MORE_BIT   = 8'h01;
    localparam logic [FRAG_W-1:0] INDEX_BITS = 8'hFE;

    // Response status codes
    localparam logic [STATUS_W-1:0] STAT_MORE     = 4'd0;
    localparam logic [STATUS_W-1:0] STAT_COMPLETE = 4'd1;
    localparam logic [STATUS_W-1:0] STAT_SINGLE   = 4'd2;
    localparam logic [STATUS_W-1:0] STAT_NOSLOT   = 4'd3;
    localparam logic [STATUS_W-1:0] STAT_ORDER    = 4'd4;
    localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 4'd5;
    localparam logic [STATUS_W-1:0] STAT_RELEASED = 4'd6;
    localparam logic [STATUS_W-1:0] STAT_NOTFOUND = 4'd7;
    localparam logic [STATUS_W-1:0] STAT_HANDLE   = 4'd8;

    // One slot context held in the table memory
    typedef struct packed {
        logic [TERM_W-1:0] terminal;
        logic [EXP_W-1:0]  expected;
        logic [LEN_W-1:0]  collected;
    } ctx_entry_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK_RD,
        S_LOOK_CMP,
        S_CLAIM,
        S_PROC,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

FILE: design/fragment_reassembly_context_table_core.sv
// Fragment reassembly context table: slot search, claim, index check and release.
//
// Requests enter on the s_axis channel: tuser carries the function code, tdata the
// terminal id, fragment byte and payload length. Each request yields exactly one
// response on the m_axis channel: tuser carries the status, tdata the slot index,
// write offset and byte total.
// A request is taken only while the sequencer is idle; s_axis_tready drops for the
// whole of its work. Unfragmented fragments and unknown function codes go straight
// to the response step. Otherwise the terminal search walks the slot table one entry
// at a time (a memory read, then a compare) until it hits or passes the last slot;
// a miss then, except for a release, walks the busy bits round-robin from the free
// pointer, one slot a cycle, up to SLOTS slots. Fragments then pass an index and
// length check before the response step.
// The response waits in an output register; while it is stalled by m_axis_tready
// the next request is still accepted and processed, and holds at its final step
// until the register frees. Reset clears all busy bits and the free pointer; the
// context memory needs no clearing since a slot's entry is read only once busy.
`default_nettype none

module fragment_reassembly_context_table_core #(
    parameter int SLOTS        = 8,
    parameter int BUFFER_BYTES = 16384
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // terminal [15:0], frag_byte [23:16], payload_len [39:24]
    input  wire logic [frct_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func [1:0]
    input  wire logic [frct_pkg::FUNC_W-1:0]    s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // slot [2:0], write_offset [18:3], total_bytes [34:19], zero fill above
    output logic [frct_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    // status [3:0]
    output logic [frct_pkg::STATUS_W-1:0]       m_axis_tuser
);
    import frct_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);
    localparam logic [LEN_W:0]   BUF_LIMIT = (LEN_W + 1)'(BUFFER_BYTES);

    state_t               state_reg, state_next;
    logic [FUNC_W-1:0]    func_reg, func_next;
    logic [TERM_W-1:0]    term_reg, term_next;
    logic [FRAG_W-1:0]    fb_reg, fb_next;
    logic [LEN_W-1:0]     len_reg, len_next;
    logic [IDX_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     step_reg, step_next;
    logic [IDX_W-1:0]     fp_reg, fp_next;
    logic [SLOTS-1:0]     busy_reg, busy_next;
    logic [EXP_W-1:0]     exp_reg, exp_next;
    logic [LEN_W-1:0]     coll_reg, coll_next;

    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [IDX_W-1:0]     res_slot_reg, res_slot_next;
    logic [LEN_W-1:0]     res_off_reg, res_off_next;
    logic [LEN_W-1:0]     res_tot_reg, res_tot_next;

    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STATUS_W-1:0]  m_tuser_reg, m_tuser_next;

    ctx_entry_t           ctx_mem [SLOTS];
    ctx_entry_t           rd_q_reg;
    logic                 mem_we;
    ctx_entry_t           mem_wdata;

    logic [LEN_W:0]       sum;
    logic [EXP_W-1:0]     frag_idx;
    logic [IDX_W+2:0]     slot_ext;
    logic                 out_free;

    // Table memory: one write and one registered read, both at the scan counter
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            ctx_mem[cnt_reg] <= mem_wdata;
        end
        rd_q_reg <= ctx_mem[cnt_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            busy_reg    <= '0;
            fp_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            fp_reg      <= fp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        term_reg       <= term_next;
        fb_reg         <= fb_next;
        len_reg        <= len_next;
        cnt_reg        <= cnt_next;
        step_reg       <= step_next;
        exp_reg        <= exp_next;
        coll_reg       <= coll_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_off_reg    <= res_off_next;
        res_tot_reg    <= res_tot_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign sum      = {1'b0, coll_reg} + {1'b0, len_reg};
    assign frag_idx = (fb_reg & INDEX_BITS) >> 1;
    assign slot_ext = (IDX_W + 3)'(res_slot_reg);
    assign out_free = !m_valid_reg || m_axis_tready;

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        term_next       = term_reg;
        fb_next         = fb_reg;
        len_next        = len_reg;
        cnt_next        = cnt_reg;
        step_next       = step_reg;
        fp_next         = fp_reg;
        busy_next       = busy_reg;
        exp_next        = exp_reg;
        coll_next       = coll_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_off_next    = res_off_reg;
        res_tot_next    = res_tot_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        mem_we          = 1'b0;
        mem_wdata       = '{terminal: term_reg, expected: '0, collected: '0};
        s_axis_tready   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    func_next       = s_axis_tuser;
                    term_next       = s_axis_tdata[15:0];
                    fb_next         = s_axis_tdata[23:16];
                    len_next        = s_axis_tdata[39:24];
                    cnt_next        = '0;
                    res_status_next = STAT_NOTFOUND;
                    res_slot_next   = '0;
                    res_off_next    = '0;
                    res_tot_next    = '0;
                    if (s_axis_tuser == FN_FRAG && s_axis_tdata[23:16] == '0) begin
                        res_status_next = STAT_SINGLE;
                        res_tot_next    = s_axis_tdata[39:24];
                        state_next      = S_RESP;
                    end else if (s_axis_tuser == FN_FRAG || s_axis_tuser == FN_RELEASE ||
                                 s_axis_tuser == FN_LOOKUP) begin
                        state_next = S_LOOK_RD;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_LOOK_RD: begin
                state_next = S_LOOK_CMP;
            end
            S_LOOK_CMP: begin
                if (busy_reg[cnt_reg] && rd_q_reg.terminal == term_reg) begin
                    exp_next      = rd_q_reg.expected;
                    coll_next     = rd_q_reg.collected;
                    res_slot_next = cnt_reg;
                    if (func_reg == FN_RELEASE) begin
                        busy_next[cnt_reg] = 1'b0;
                        res_status_next    = STAT_RELEASED;
                        state_next         = S_RESP;
                    end else if (func_reg == FN_FRAG) begin
                        state_next = S_PROC;
                    end else begin
                        res_status_next = STAT_HANDLE;
                        res_off_next    = rd_q_reg.collected;
                        res_tot_next    = rd_q_reg.collected;
                        state_next      = S_RESP;
                    end
                end else if (cnt_reg == LAST_SLOT) begin
                    if (func_reg == FN_RELEASE) begin
                        state_next = S_RESP;
                    end else begin
                        // start the round-robin claim at the free pointer
                        cnt_next   = fp_reg;
                        step_next  = '0;
                        state_next = S_CLAIM;
                    end
                end else begin
                    cnt_next   = cnt_reg + IDX_W'(1);
                    state_next = S_LOOK_RD;
                end
            end
            S_CLAIM: begin
                if (!busy_reg[cnt_reg]) begin
                    busy_next[cnt_reg] = 1'b1;
                    mem_we             = 1'b1;
                    fp_next            = cnt_reg;
                    exp_next           = '0;
                    coll_next          = '0;
                    res_slot_next      = cnt_reg;
                    if (func_reg == FN_FRAG) begin
                        state_next = S_PROC;
                    end else begin
                        res_status_next = STAT_HANDLE;
                        state_next      = S_RESP;
                    end
                end else if (step_reg == LAST_SLOT) begin
                    res_status_next = STAT_NOSLOT;
                    state_next      = S_RESP;
                end else begin
                    step_next = step_reg + IDX_W'(1);
                    cnt_next  = (cnt_reg == LAST_SLOT) ? '0 : cnt_reg + IDX_W'(1);
                end
            end
            S_PROC: begin
                state_next = S_RESP;
                if (exp_reg != frag_idx) begin
                    busy_next[cnt_reg] = 1'b0;
                    res_status_next    = STAT_ORDER;
                end else if (sum > BUF_LIMIT) begin
                    busy_next[cnt_reg] = 1'b0;
                    res_status_next    = STAT_OVERFLOW;
                    res_off_next       = coll_reg;
                end else begin
                    mem_we          = 1'b1;
                    mem_wdata       = '{terminal:  term_reg,
                                        expected:  frag_idx + EXP_W'(1),
                                        collected: sum[LEN_W-1:0]};
                    res_off_next    = coll_reg;
                    res_tot_next    = sum[LEN_W-1:0];
                    res_status_next = ((fb_reg & MORE_BIT) != '0) ? STAT_MORE
                                                                   : STAT_COMPLETE;
                end
            end
            S_RESP: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_tuser_next = res_status_reg;
                    m_tdata_next = {5'b0, res_tot_reg, res_off_reg, slot_ext[2:0]};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while previous one in progress");

    a_busy_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(busy_reg) <= $countones($past(busy_reg)) + 1)
        else $error("more than one slot claimed in a cycle");

    a_total_ge_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RESP && (res_status_reg == STAT_MORE ||
                                res_status_reg == STAT_COMPLETE)
        |-> res_tot_reg >= res_off_reg)
        else $error("byte total below write offset");

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= STAT_HANDLE)
        else $error("status code out of range");
`endif

endmodule

`default_nettype wire
